// ----- hw/rtl/krs_pkg.sv -----
// ----------------------------------------------------------------------------
// krs_pkg
// Shared types and codes of the keyed record stack: item structs,
// operation and status codes, controller to datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package krs_pkg;

	localparam int WORD_W      = 32;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_OUT_W = 5;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam op_t OP_PUSH   = 3'd0;
	localparam op_t OP_POP    = 3'd1;
	localparam op_t OP_PEEK   = 3'd2;
	localparam op_t OP_UPDATE = 3'd3;
	localparam op_t OP_DELETE = 3'd4;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

	typedef struct packed {
		op_t               operation;
		logic [WORD_W-1:0] in_key;
		logic [WORD_W-1:0] in_payload;
	} in_item_t;

	typedef struct packed {
		status_t                status;
		logic [WORD_W-1:0]      out_key;
		logic [WORD_W-1:0]      out_payload;
		logic [DEPTH_OUT_W-1:0] depth;
		logic                   empty_flag;
		logic                   full_flag;
	} out_item_t;

	typedef struct packed {
		logic    cap;
		logic    push_wr;
		logic    top_rd;
		logic    take_top;
		logic    init_up;
		logic    init_dn;
		logic    scan_rd;
		logic    upd_wr;
		logic    scan_dec;
		logic    del_step;
		logic    del_fin;
		logic    st_set;
		status_t st_code;
		logic    res_ld;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic match;
		logic at_bottom;
		logic at_top;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/krs_dp.sv -----
// ----------------------------------------------------------------------------
// krs_dp
// Datapath of the keyed record stack: record memory, depth counter, scan
// index, compaction write pointer, key compare and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module krs_dp #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire krs_pkg::in_item_t  item,
	input  wire krs_pkg::dp_cmd_t   cmd,
	output krs_pkg::dp_sts_t        sts,
	output krs_pkg::out_item_t      res
);

	localparam int WW = krs_pkg::WORD_W;
	localparam int KW = (KEY_WIDTH < WW) ? KEY_WIDTH : WW;
	localparam int RW = KW + WW;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int DW = krs_pkg::DEPTH_OUT_W;

	logic [RW-1:0]      mem [DEPTH];
	logic [RW-1:0]      rd_q;
	krs_pkg::op_t       op_q;
	logic [KW-1:0]      key_q;
	logic [WW-1:0]      pay_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      wr_q;
	logic               found_q;
	krs_pkg::status_t   st_q;
	logic [KW-1:0]      okey_q;
	logic [WW-1:0]      opay_q;
	krs_pkg::out_item_t res_q;

	logic [KW-1:0] rd_key;
	logic [WW-1:0] rd_pay;
	logic [AW-1:0] top_idx;
	logic [CW-1:0] count_m1;
	logic          match;
	logic          rd_en;
	logic [AW-1:0] raddr;
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [RW-1:0] wdata;

	assign rd_key   = rd_q[RW-1:WW];
	assign rd_pay   = rd_q[WW-1:0];
	assign count_m1 = count_q - CW'(1);
	assign top_idx  = AW'(count_m1);
	assign match    = (rd_key == key_q);

	assign rd_en = cmd.top_rd | cmd.scan_rd;
	assign raddr = cmd.top_rd ? top_idx : idx_q;

	always_comb begin
		wr_en = 1'b0;
		waddr = idx_q;
		wdata = rd_q;
		if (cmd.push_wr) begin
			wr_en = 1'b1;
			waddr = AW'(count_q);
			wdata = {key_q, pay_q};
		end else if (cmd.upd_wr) begin
			wr_en = 1'b1;
			waddr = idx_q;
			wdata = {rd_key, pay_q};
		end else if (cmd.del_step && !match) begin
			wr_en = 1'b1;
			waddr = AW'(wr_q);
			wdata = rd_q;
		end
	end

	// record memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_wr) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.take_top && op_q == krs_pkg::OP_POP) begin
			count_q <= count_m1;
		end else if (cmd.del_fin) begin
			count_q <= wr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= item.operation;
			key_q  <= item.in_key[KW-1:0];
			pay_q  <= item.in_payload;
			st_q   <= krs_pkg::ST_OK;
			okey_q <= '0;
			opay_q <= '0;
		end else begin
			if (cmd.st_set) begin
				st_q <= cmd.st_code;
			end else if (cmd.del_fin && !found_q) begin
				st_q <= krs_pkg::ST_NOTFOUND;
			end
			if (cmd.take_top) begin
				okey_q <= rd_key;
				opay_q <= rd_pay;
			end
		end

		if (cmd.init_up) begin
			idx_q <= top_idx;
		end else if (cmd.init_dn) begin
			idx_q <= '0;
		end else if (cmd.scan_dec) begin
			idx_q <= idx_q - AW'(1);
		end else if (cmd.del_step) begin
			idx_q <= idx_q + AW'(1);
		end

		if (cmd.init_dn) begin
			wr_q    <= '0;
			found_q <= 1'b0;
		end else if (cmd.del_step) begin
			if (match) begin
				found_q <= 1'b1;
			end else begin
				wr_q <= wr_q + CW'(1);
			end
		end

		if (cmd.res_ld) begin
			res_q.status      <= st_q;
			res_q.out_key     <= WW'(okey_q);
			res_q.out_payload <= opay_q;
			res_q.depth       <= DW'(count_q);
			res_q.empty_flag  <= (count_q == '0);
			res_q.full_flag   <= (count_q == CW'(DEPTH));
		end
	end

	assign sts.op        = op_q;
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.match     = match;
	assign sts.at_bottom = (idx_q == '0);
	assign sts.at_top    = (CW'(idx_q) == count_m1);
	assign res           = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/krs_ctrl.sv -----
// ----------------------------------------------------------------------------
// krs_ctrl
// Controller of the keyed record stack: sequences each operation over the
// datapath and owns the input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module krs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	output logic                   res_valid,
	input  wire logic              res_stall,
	input  wire krs_pkg::dp_sts_t  sts,
	output krs_pkg::dp_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_TOPW = 3'd2;
	localparam logic [2:0] S_SRD  = 3'd3;
	localparam logic [2:0] S_SCMP = 3'd4;
	localparam logic [2:0] S_DFIN = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       res_valid_q;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd.cap  = 1'b1;
					state_nx = S_DISP;
				end
			end
			S_DISP: begin
				state_nx = S_FIN;
				case (sts.op)
					krs_pkg::OP_PUSH: begin
						if (sts.full) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = krs_pkg::ST_FULL;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					krs_pkg::OP_POP, krs_pkg::OP_PEEK: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = krs_pkg::ST_EMPTY;
						end else begin
							cmd.top_rd = 1'b1;
							state_nx   = S_TOPW;
						end
					end
					krs_pkg::OP_UPDATE: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = krs_pkg::ST_NOTFOUND;
						end else begin
							cmd.init_up = 1'b1;
							state_nx    = S_SRD;
						end
					end
					krs_pkg::OP_DELETE: begin
						if (sts.empty) begin
							cmd.st_set  = 1'b1;
							cmd.st_code = krs_pkg::ST_NOTFOUND;
						end else begin
							cmd.init_dn = 1'b1;
							state_nx    = S_SRD;
						end
					end
					default: begin
						state_nx = S_FIN;
					end
				endcase
			end
			S_TOPW: begin
				cmd.take_top = 1'b1;
				state_nx     = S_FIN;
			end
			S_SRD: begin
				cmd.scan_rd = 1'b1;
				state_nx    = S_SCMP;
			end
			S_SCMP: begin
				if (sts.op == krs_pkg::OP_UPDATE) begin
					if (sts.match) begin
						cmd.upd_wr = 1'b1;
						state_nx   = S_FIN;
					end else if (sts.at_bottom) begin
						cmd.st_set  = 1'b1;
						cmd.st_code = krs_pkg::ST_NOTFOUND;
						state_nx    = S_FIN;
					end else begin
						cmd.scan_dec = 1'b1;
						state_nx     = S_SRD;
					end
				end else begin
					cmd.del_step = 1'b1;
					state_nx     = sts.at_top ? S_DFIN : S_SRD;
				end
			end
			S_DFIN: begin
				cmd.del_fin = 1'b1;
				state_nx    = S_FIN;
			end
			S_FIN: begin
				if (!res_valid_q || !res_stall) begin
					cmd.res_ld = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.res_ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/keyed_record_stack_unit.sv -----
// ----------------------------------------------------------------------------
// keyed_record_stack_unit
// Bounded LIFO stack of key/payload records with push, pop, peek, update by
// key and delete by key; one result item per input item.
//
// The cmd channel takes one item at a time: cmd_stall is high from the cycle
// after an accept until the result has been placed in the output register.
// Each item yields one res item, held in that register until taken, so the
// next cmd item is accepted while a result still waits on res_stall.
// Sequence from accept to res_valid, with n records held: push, unknown
// codes, and pop, peek, update or delete on an empty stack go from dispatch
// to the final state; pop and peek first read the top record and take it;
// update reads and compares records from the top down until a match or the
// bottom; delete examines all n records from the bottom up, compacting those
// that do not match, then sets the new depth. The memory has one read and one
// write port with registered read data, and the key search reads a record in
// S_SRD and compares it in S_SCMP.
// A stalled result holds the next item in the final state of the controller until taken.
// Reset empties the stack and drops any pending result; record contents are
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_stack_unit #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire krs_pkg::in_item_t cmd,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output krs_pkg::out_item_t     res
);

	krs_pkg::dp_cmd_t dp_cmd;
	krs_pkg::dp_sts_t dp_sts;

	krs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	krs_dp #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd),
		.cmd    (dp_cmd),
		.sts    (dp_sts),
		.res    (res)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("item accepted while previous item in flight");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.push_wr |-> !dp_sts.full)
		else $error("push written into a full stack");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.res_ld |-> !(res_valid && res_stall))
		else $error("result register loaded while result stalled");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.empty_flag && res.full_flag))
		else $error("empty and full flags both set");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == krs_pkg::ST_EMPTY |-> res.empty_flag)
		else $error("empty status on a non-empty stack");

endmodule

`default_nettype wire
